### rtl/indexed_list_store_assert.svh
// Assertion macros for the indexed list store.
// Each macro expands to one labeled concurrent assertion on clk, disabled in reset.
`ifndef INDEXED_LIST_STORE_ASSERT_SVH
`define INDEXED_LIST_STORE_ASSERT_SVH

// Same-cycle implication.
`define ILS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("indexed_list_store assertion failed");

// Next-cycle implication.
`define ILS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("indexed_list_store assertion failed");

`endif

### rtl/ils_pkg.sv
// Package for the indexed list store: operation and status codes, field widths,
// and the command bundle broadcast to the row of entry cells. No dependencies.
`timescale 1ns / 1ps

package ils_pkg;

	localparam int MODE_W   = 3;
	localparam int POS_W    = 7;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int FPOS_W   = 6;
	localparam int COUNT_W  = 7;

	// Width of one group of match bits examined per scan cycle.
	localparam int CHUNK_W     = 8;
	localparam int CHUNK_IDX_W = 3;

	localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
	localparam logic [MODE_W-1:0] MODE_GET    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FIND   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd4;
	localparam logic [MODE_W-1:0] MODE_SET    = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

	// Operations that change the store, each already qualified as legal.
	typedef struct packed {
		logic op_append;
		logic op_insert;
		logic op_remove;
		logic op_set;
	} cell_cmd_t;

endpackage

### rtl/ils_cell.sv
// One entry of the list store: holds a word, trades it with its neighbors
// and compares it with the search key. Depends on ils_pkg.
`timescale 1ns / 1ps

module ils_cell import ils_pkg::*; #(
	parameter int INDEX = 0,
	parameter int XW    = 8
) (
	input  logic              clk,
	input  cell_cmd_t         cmd,
	input  logic [XW-1:0]     pos,
	input  logic [XW-1:0]     cnt,
	input  logic [DATA_W-1:0] value,
	input  logic [DATA_W-1:0] lower,
	input  logic [DATA_W-1:0] upper,
	output logic [DATA_W-1:0] entry,
	output logic              match
);

	localparam logic [XW-1:0] IDX   = XW'(INDEX);
	localparam logic [XW-1:0] IDX_N = XW'(INDEX + 1);

	logic [DATA_W-1:0] entry_q;
	logic [DATA_W-1:0] nxt;
	logic              we;

	always_comb begin
		nxt = value;
		we  = 1'b0;
		priority if (cmd.op_append && IDX == cnt) begin
			we = 1'b1;
		end else if (cmd.op_insert && IDX == pos) begin
			we = 1'b1;
		end else if (cmd.op_insert && IDX > pos && IDX <= cnt) begin
			nxt = lower;
			we  = 1'b1;
		end else if (cmd.op_remove && IDX >= pos && IDX_N < cnt) begin
			nxt = upper;
			we  = 1'b1;
		end else if (cmd.op_set && IDX == pos) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			entry_q <= nxt;
		end
	end

	assign entry = entry_q;
	assign match = (entry_q == value) && (IDX < cnt);

endmodule

### rtl/ils_scan.sv
// First-match finder: walks a captured match vector one group of bits per cycle
// and reports the lowest set position. Depends on ils_pkg.
`timescale 1ns / 1ps

module ils_scan import ils_pkg::*; #(
	parameter int DEPTH = 64,
	localparam int NCH = (DEPTH + CHUNK_W - 1) / CHUNK_W,
	localparam int KW  = (NCH > 1) ? $clog2(NCH) : 1,
	localparam int IW  = KW + CHUNK_IDX_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DEPTH-1:0] match,
	output logic             busy,
	output logic             done,
	output logic             hit,
	output logic [IW-1:0]    idx
);

	localparam int VW = NCH * CHUNK_W;
	localparam logic S_IDLE = 1'b0;
	localparam logic S_RUN  = 1'b1;

	logic                   state_q;
	logic [KW-1:0]          k_q;
	logic [VW-1:0]          vec_q;
	logic [CHUNK_W-1:0]     chunk;
	logic [CHUNK_IDX_W-1:0] enc;

	assign chunk = vec_q[CHUNK_W-1:0];
	assign busy  = (state_q == S_RUN);
	assign hit   = |chunk;
	assign done  = busy && (hit || k_q == KW'(NCH - 1));
	assign idx   = {k_q, enc};

	always_comb begin
		enc = '0;
		for (int j = CHUNK_W - 1; j >= 0; j--) begin
			if (chunk[j]) begin
				enc = CHUNK_IDX_W'(j);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_RUN;
						k_q     <= '0;
					end
				end
				S_RUN: begin
					if (done) begin
						state_q <= S_IDLE;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			vec_q <= VW'(match);
		end else begin
			vec_q <= vec_q >> CHUNK_W;
		end
	end

endmodule

### rtl/indexed_list_store.sv
// Append, insert, get, remove, set and unused modes answer in the cycle after they are accepted.
// Find: the first-match scan walks the captured matches in groups of eight cells and
// holds busy meanwhile; the answer is registered after the scan ends.
// One word per cycle is taken for all operations but find, while no find is being scanned.
// Reset clears the entry count and the scanner; stored entries keep their contents.
// The receiver cannot stall: done marks each result for exactly one cycle.
`timescale 1ns / 1ps

`include "indexed_list_store_assert.svh"

module indexed_list_store import ils_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [MODE_W-1:0]   mode,
	input  logic [POS_W-1:0]    position,
	input  logic [DATA_W-1:0]   value,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [DATA_W-1:0]   read_value,
	output logic                found,
	output logic [FPOS_W-1:0]   found_position,
	output logic [COUNT_W-1:0]  entry_count
);

	// Count must hold DEPTH itself; comparisons run at the wider of count and position.
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int XW  = (CW > POS_W) ? CW : POS_W;
	localparam int NCH = (DEPTH + CHUNK_W - 1) / CHUNK_W;
	localparam int KW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int IW  = KW + CHUNK_IDX_W;
	localparam int FW  = (IW > FPOS_W) ? IW : FPOS_W;
	localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_nxt;
	logic [XW-1:0]     cnt_x;
	logic [XW-1:0]     pos_x;
	logic              accept;
	cell_cmd_t         cmd;
	logic [DATA_W-1:0] ent   [DEPTH];
	logic [DEPTH-1:0]  match;
	logic [STATUS_W-1:0] st;
	logic [DATA_W-1:0] rd;

	logic          scan_start;
	logic          scan_busy;
	logic          scan_done;
	logic          scan_hit;
	logic [IW-1:0] scan_idx;
	logic [FW-1:0] idx_x;

	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [DATA_W-1:0]   read_value_q;
	logic                found_q;
	logic [FPOS_W-1:0]   found_position_q;

	// A word is taken only while no find is being scanned.
	assign busy   = scan_busy;
	assign accept = start && !busy;
	assign cnt_x  = XW'(count_q);
	assign pos_x  = XW'(position);
	assign idx_x  = FW'(scan_idx);

	// Decode the operation, check position before fullness, and build the cell command.
	always_comb begin
		cmd        = '0;
		st         = ST_OK;
		count_nxt  = count_q;
		scan_start = 1'b0;
		unique case (mode)
			MODE_APPEND: begin
				if (cnt_x >= DEPTH_X) begin
					st = ST_FULL;
				end else begin
					cmd.op_append = accept;
					count_nxt     = count_q + 1'b1;
				end
			end
			MODE_INSERT: begin
				if (pos_x > cnt_x) begin
					st = ST_BAD_POS;
				end else if (cnt_x >= DEPTH_X) begin
					st = ST_FULL;
				end else begin
					cmd.op_insert = accept;
					count_nxt     = count_q + 1'b1;
				end
			end
			MODE_GET: begin
				if (pos_x >= cnt_x) begin
					st = ST_BAD_POS;
				end
			end
			MODE_FIND: begin
				scan_start = accept;
			end
			MODE_REMOVE: begin
				if (pos_x >= cnt_x) begin
					st = ST_BAD_POS;
				end else begin
					cmd.op_remove = accept;
					count_nxt     = count_q - 1'b1;
				end
			end
			MODE_SET: begin
				if (pos_x >= cnt_x) begin
					st = ST_BAD_POS;
				end else begin
					cmd.op_set = accept;
				end
			end
			default: begin
			end
		endcase
	end

	// The row of cells. Each one sees its neighbors' words for the shifts of
	// insert and remove; the ends of the row take zero.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] lower;
		logic [DATA_W-1:0] upper;
		if (i == 0) begin : g_first
			assign lower = '0;
		end else begin : g_lower
			assign lower = ent[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign upper = '0;
		end else begin : g_upper
			assign upper = ent[i+1];
		end
		ils_cell #(
			.INDEX(i),
			.XW   (XW)
		) u_cell (
			.clk  (clk),
			.cmd  (cmd),
			.pos  (pos_x),
			.cnt  (cnt_x),
			.value(value),
			.lower(lower),
			.upper(upper),
			.entry(ent[i]),
			.match(match[i])
		);
	end

	// A get reads its entry through a one-hot select over the row.
	always_comb begin
		rd = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (pos_x == XW'(i)) begin
				rd = rd | ent[i];
			end
		end
	end

	// Find captures every cell's compare at accept and then walks it group by group.
	ils_scan #(
		.DEPTH(DEPTH)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.start (scan_start),
		.match (match),
		.busy  (scan_busy),
		.done  (scan_done),
		.hit   (scan_hit),
		.idx   (scan_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_nxt;
			end
			done_q <= (accept && mode != MODE_FIND) || scan_done;
		end
	end

	// Result word registers; a find miss reports zero position.
	always_ff @(posedge clk) begin
		if (scan_done) begin
			status_q         <= ST_OK;
			read_value_q     <= '0;
			found_q          <= scan_hit;
			found_position_q <= scan_hit ? idx_x[FPOS_W-1:0] : '0;
		end else if (accept) begin
			status_q         <= st;
			read_value_q     <= (mode == MODE_GET && st == ST_OK) ? rd : '0;
			found_q          <= 1'b0;
			found_position_q <= '0;
		end
	end

	logic [XW-1:0] count_out_x;
	assign count_out_x = XW'(count_q);

	assign done           = done_q;
	assign status         = status_q;
	assign read_value     = read_value_q;
	assign found          = found_q;
	assign found_position = found_position_q;
	assign entry_count    = count_out_x[COUNT_W-1:0];

	// The count never passes the store depth.
	`ILS_ASSERT_IMP(a_count_bound, 1'b1, count_out_x <= DEPTH_X)
	// A find that is taken holds the port busy in the next cycle.
	`ILS_ASSERT_NEXT(a_find_busy, accept && mode == MODE_FIND, busy)
	// Every other operation answers in the next cycle.
	`ILS_ASSERT_NEXT(a_quick_done, accept && mode != MODE_FIND, done)
	// A hit is only ever reported with an ok status.
	`ILS_ASSERT_IMP(a_found_ok, done && found, status == ST_OK)

endmodule

### tb/ils_result_compare.sv
// Result checker for the indexed list store: keeps its own copy of the list,
// predicts each word's answer at acceptance and compares it with the answer
// that comes back. Depends on ils_pkg.
`timescale 1ns / 1ps

module ils_result_compare import ils_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic [MODE_W-1:0]   mode,
	input  logic [POS_W-1:0]    position,
	input  logic [DATA_W-1:0]   value,
	input  logic                done,
	input  logic [STATUS_W-1:0] status,
	input  logic [DATA_W-1:0]   read_value,
	input  logic                found,
	input  logic [FPOS_W-1:0]   found_position,
	input  logic [COUNT_W-1:0]  entry_count,
	output int                  mismatches,
	output int                  answers_owed
);

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DATA_W-1:0]   read_value;
		logic                found;
		logic [FPOS_W-1:0]   found_position;
		logic [COUNT_W-1:0]  entry_count;
	} list_answer_t;

	logic [DATA_W-1:0] mirror_entries [DEPTH];
	int unsigned       mirror_len;
	list_answer_t      owed_answers [$];

	// Applies one operation to the mirror list and returns the answer it should produce.
	function automatic list_answer_t apply_list_op(input logic [MODE_W-1:0] op,
			input logic [POS_W-1:0] pos, input logic [DATA_W-1:0] val);
		list_answer_t ans;
		int unsigned  p;
		p = 32'(pos);
		ans = '0;
		case (op)
			MODE_APPEND: begin
				if (mirror_len >= DEPTH) begin
					ans.status = ST_FULL;
				end else begin
					mirror_entries[mirror_len] = val;
					mirror_len++;
				end
			end
			MODE_INSERT: begin
				if (p > mirror_len) begin
					ans.status = ST_BAD_POS;
				end else if (mirror_len >= DEPTH) begin
					ans.status = ST_FULL;
				end else begin
					for (int unsigned i = mirror_len; i > p; i--)
						mirror_entries[i] = mirror_entries[i-1];
					mirror_entries[p] = val;
					mirror_len++;
				end
			end
			MODE_GET: begin
				if (p >= mirror_len)
					ans.status = ST_BAD_POS;
				else
					ans.read_value = mirror_entries[p];
			end
			MODE_FIND: begin
				for (int unsigned i = 0; i < mirror_len; i++) begin
					if (!ans.found && mirror_entries[i] == val) begin
						ans.found = 1'b1;
						ans.found_position = i[FPOS_W-1:0];
					end
				end
			end
			MODE_REMOVE: begin
				if (p >= mirror_len) begin
					ans.status = ST_BAD_POS;
				end else begin
					for (int unsigned i = p; i + 1 < mirror_len; i++)
						mirror_entries[i] = mirror_entries[i+1];
					mirror_len--;
				end
			end
			MODE_SET: begin
				if (p >= mirror_len)
					ans.status = ST_BAD_POS;
				else
					mirror_entries[p] = val;
			end
			default: begin
			end
		endcase
		ans.entry_count = mirror_len[COUNT_W-1:0];
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_answer_t want;
		list_answer_t got;
		if (!arst_n) begin
			mirror_len = 0;
			owed_answers.delete();
			mismatches = 0;
			answers_owed = 0;
		end else begin
			// An answer always belongs to a word accepted at an earlier edge, so it is
			// matched before this edge's word is queued.
			if (done) begin
				got = '{status, read_value, found, found_position, entry_count};
				if (owed_answers.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: answer with no word outstanding: %s%0d %h %b %0d %0d",
							$realtime, "st rd f fp n = ", got.status,
							got.read_value, got.found, got.found_position,
							got.entry_count);
					mismatches++;
				end else begin
					want = owed_answers.pop_front();
					if (got.status != want.status || got.read_value != want.read_value ||
							got.found != want.found || got.found_position != want.found_position ||
							got.entry_count != want.entry_count) begin
						if (mismatches < 10) begin
							$write("%0t: expected st=%0d rd=%h f=%b fp=%0d n=%0d",
								$realtime, want.status, want.read_value, want.found,
								want.found_position, want.entry_count);
							$display(", got st=%0d rd=%h f=%b fp=%0d n=%0d",
								got.status, got.read_value, got.found,
								got.found_position, got.entry_count);
						end
						mismatches++;
					end
				end
			end
			if (start && !busy)
				owed_answers.push_back(apply_list_op(mode, position, value));
			answers_owed = owed_answers.size();
		end
	end

endmodule

### tb/indexed_list_store_tb.sv
// Top of the indexed list store testbench: clock, reset, command stimulus and the verdict.
// Depends on ils_pkg, the indexed_list_store block and the ils_result_compare checker.
`timescale 1ns / 1ps

module indexed_list_store_tb import ils_pkg::*;;

	localparam int DEPTH = 64;

	// Mode codes the block leaves unused; they must act as no-ops.
	localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

	// Flavors of random traffic: grow the list, shrink it, or a bit of everything.
	localparam int MIX_FILL  = 0;
	localparam int MIX_DRAIN = 1;
	localparam int MIX_EVEN  = 2;

	localparam int SEGMENT_WORDS  = 100;
	localparam int WATCHDOG_LIMIT = 2000;
	// Find is the slowest operation; the tail wait covers its longest scan with margin.
	localparam int TAIL_CYCLES    = 12;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [MODE_W-1:0]   mode = MODE_APPEND;
	logic [POS_W-1:0]    position = '0;
	logic [DATA_W-1:0]   value = '0;
	logic                busy;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [DATA_W-1:0]   read_value;
	logic                found;
	logic [FPOS_W-1:0]   found_position;
	logic [COUNT_W-1:0]  entry_count;

	int                  mismatches;
	int                  answers_owed;
	int                  stall_cycles = 0;
	// Last entry count reported by the block; it steers positions toward the live range.
	int                  seen_count = 0;
	logic [DATA_W-1:0]   value_pool [8];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	indexed_list_store #(.DEPTH(DEPTH)) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.position       (position),
		.value          (value),
		.done           (done),
		.status         (status),
		.read_value     (read_value),
		.found          (found),
		.found_position (found_position),
		.entry_count    (entry_count)
	);

	ils_result_compare #(.DEPTH(DEPTH)) u_compare (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.position       (position),
		.value          (value),
		.done           (done),
		.status         (status),
		.read_value     (read_value),
		.found          (found),
		.found_position (found_position),
		.entry_count    (entry_count),
		.mismatches     (mismatches),
		.answers_owed   (answers_owed)
	);

	always @(posedge clk) begin
		if (done)
			seen_count <= int'(entry_count);
	end

	// The watchdog resets whenever a word goes in or an answer comes out; a long quiet
	// spell means the block has hung or lost an answer.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Presents one word and holds it until the block takes it. When idling is allowed,
	// start drops for a random number of cycles first, about 30 percent of the time.
	task automatic send_word(input logic [MODE_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic [DATA_W-1:0] val, input bit may_idle);
		if (may_idle) begin
			while ($urandom_range(0, 99) < 30) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start    <= 1'b1;
		mode     <= op;
		position <= pos;
		value    <= val;
		do @(posedge clk); while (busy);
	endtask

	function automatic logic [MODE_W-1:0] pick_mode(input int mix);
		int roll;
		roll = $urandom_range(0, 99);
		case (mix)
			MIX_FILL: begin
				if (roll < 38)      return MODE_APPEND;
				else if (roll < 68) return MODE_INSERT;
				else if (roll < 78) return MODE_GET;
				else if (roll < 88) return MODE_FIND;
				else if (roll < 92) return MODE_REMOVE;
				else if (roll < 98) return MODE_SET;
			end
			MIX_DRAIN: begin
				if (roll < 5)       return MODE_APPEND;
				else if (roll < 10) return MODE_INSERT;
				else if (roll < 20) return MODE_GET;
				else if (roll < 30) return MODE_FIND;
				else if (roll < 90) return MODE_REMOVE;
				else if (roll < 98) return MODE_SET;
			end
			default: begin
				if (roll < 16)      return MODE_APPEND;
				else if (roll < 32) return MODE_INSERT;
				else if (roll < 50) return MODE_GET;
				else if (roll < 68) return MODE_FIND;
				else if (roll < 84) return MODE_REMOVE;
				else if (roll < 98) return MODE_SET;
			end
		endcase
		return (roll[0]) ? MODE_SPARE_HI : MODE_SPARE_LO;
	endfunction

	// Values come mostly from a small pool so that finds hit, with the extremes and
	// fully random words mixed in.
	function automatic logic [DATA_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return value_pool[$urandom_range(0, 7)];
		else if (roll < 50)
			return 32'h8000_0000;
		else if (roll < 55)
			return 32'h7FFF_FFFF;
		else if (roll < 58)
			return '0;
		else if (roll < 61)
			return '1;
		return $urandom;
	endfunction

	// Positions mostly land in or just past the live range; the rest span the whole
	// port, out-of-range values above the store size included.
	function automatic logic [POS_W-1:0] pick_position();
		if ($urandom_range(0, 99) < 85)
			return POS_W'($urandom_range(0, seen_count));
		return POS_W'($urandom_range(0, (1 << POS_W) - 1));
	endfunction

	initial begin
		int mix;
		foreach (value_pool[i])
			value_pool[i] = $urandom;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words. Every operation on the empty list fails or misses first.
		send_word(MODE_GET,    7'd0,   32'h0,         1'b0);
		send_word(MODE_REMOVE, 7'd0,   32'h0,         1'b0);
		send_word(MODE_SET,    7'd0,   32'h1234_5678, 1'b0);
		send_word(MODE_FIND,   7'd0,   32'h0,         1'b0);
		send_word(MODE_INSERT, 7'd1,   32'h1,         1'b0);
		// Insert at position zero of an empty list, then appends of the extremes.
		send_word(MODE_INSERT, 7'd0,   32'h8000_0000, 1'b0);
		send_word(MODE_APPEND, 7'd0,   32'h7FFF_FFFF, 1'b0);
		send_word(MODE_APPEND, 7'd127, 32'hFFFF_FFFF, 1'b0);
		send_word(MODE_APPEND, 7'd0,   32'h0,         1'b0);
		// Insert in the middle and right at the end, both legal.
		send_word(MODE_INSERT, 7'd1,   32'h5,         1'b0);
		send_word(MODE_INSERT, 7'd5,   32'hA5A5_5A5A, 1'b0);
		send_word(MODE_GET,    7'd0,   32'h0,         1'b0);
		send_word(MODE_GET,    7'd5,   32'h0,         1'b0);
		send_word(MODE_GET,    7'd6,   32'h0,         1'b0);
		send_word(MODE_GET,    7'd127, 32'h0,         1'b0);
		// Finds: a hit, a miss, and a value held twice so the first position wins.
		send_word(MODE_FIND,   7'd0,   32'h7FFF_FFFF, 1'b0);
		send_word(MODE_FIND,   7'd0,   32'h0001_2345, 1'b0);
		send_word(MODE_SET,    7'd4,   32'h8000_0000, 1'b0);
		send_word(MODE_FIND,   7'd0,   32'h8000_0000, 1'b0);
		// Removes at the head and the tail, and one just past the end.
		send_word(MODE_REMOVE, 7'd0,   32'h0,         1'b0);
		send_word(MODE_REMOVE, 7'd4,   32'h0,         1'b0);
		send_word(MODE_REMOVE, 7'd4,   32'h0,         1'b0);
		// The spare mode codes do nothing.
		send_word(MODE_SPARE_LO, 7'd0, 32'hFFFF_FFFF, 1'b0);
		send_word(MODE_SPARE_HI, 7'd3, 32'h0,         1'b0);

		// Random traffic in segments. The first one grows the list, and a middle stretch
		// runs with no idling at all.
		for (int seg = 0; seg < 5; seg++) begin
			case (seg)
				0: mix = MIX_FILL;
				1: mix = MIX_DRAIN;
				2: mix = MIX_EVEN;
				3: mix = MIX_FILL;
				default: mix = MIX_DRAIN;
			endcase
			for (int w = 0; w < SEGMENT_WORDS; w++)
				send_word(pick_mode(mix), pick_position(), pick_value(), seg != 2);
		end

		start <= 1'b0;
		while (answers_owed != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/ils_pkg.sv
rtl/ils_cell.sv
rtl/ils_scan.sv
rtl/indexed_list_store.sv
tb/ils_result_compare.sv
tb/indexed_list_store_tb.sv
